>>> hdl/phsin_pkg.sv
// Shared constants and elaboration-time helpers for the phase-to-sine converter.
// Holds the Q62 series arithmetic used to build the quarter-wave sine table.
// No dependencies.
package phsin_pkg;

  localparam int unsigned PhaseW      = 32;
  localparam int unsigned QuarterW    = 30;
  localparam int unsigned SeriesTerms = 40;
  localparam logic [63:0] HalfPiQ62   = 64'h6487ED5110B4611A;

  function automatic logic [63:0] mul_q62(logic [63:0] a, logic [63:0] b);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return prod[125:62];
  endfunction

  // Restoring shift-and-subtract quotient, evaluated only while the table is built.
  function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic logic [63:0] sine_q62(logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] den;
    logic        done;
    x2   = mul_q62(x, x);
    term = x;
    sum  = x;
    done = 1'b0;
    for (int k = 1; k < SeriesTerms; k++) begin
      if (!done) begin
        if (term == 64'd0) begin
          done = 1'b1;
        end else begin
          den  = 64'(2 * k * (2 * k + 1));
          term = udiv64(mul_q62(term, x2), den);
          if (k[0]) begin
            sum = sum - term;
          end else begin
            sum = sum + term;
          end
        end
      end
    end
    return sum;
  endfunction

endpackage

>>> hdl/phsin_rom.sv
// Quarter-wave sine table with registered reads of two neighboring entries.
// The contents are computed at elaboration with the series helpers of phsin_pkg.
// Depends on phsin_pkg.
module phsin_rom #(
  parameter int unsigned TableSize = 256,
  parameter int unsigned FracBits  = 16,
  parameter int unsigned IdxW      = $clog2(TableSize + 1)
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [IdxW-1:0]     idx_i,
  output logic [FracBits:0]   entry_lo_o,
  output logic [FracBits:0]   entry_hi_o
);
  import phsin_pkg::*;

  typedef logic [FracBits:0] entry_t;
  typedef entry_t rom_t [TableSize+1];

  localparam logic [63:0] StepQ = HalfPiQ62 / 64'(TableSize);
  localparam logic [63:0] StepR = HalfPiQ62 % 64'(TableSize);

  function automatic rom_t build_rom();
    rom_t        rom;
    logic [63:0] x;
    logic [63:0] s;
    for (int unsigned i = 0; i < TableSize; i++) begin
      x      = StepQ * 64'(i) + udiv64(StepR * 64'(i), 64'(TableSize));
      s      = sine_q62(x);
      rom[i] = entry_t'((s + (64'd1 << (61 - FracBits))) >> (62 - FracBits));
    end
    rom[TableSize] = entry_t'(64'd1 << FracBits);
    return rom;
  endfunction

  localparam rom_t SineRom = build_rom();

  logic [IdxW-1:0] idx_next;
  entry_t          entry_lo_q;
  entry_t          entry_hi_q;

  assign idx_next = idx_i + IdxW'(1);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      entry_lo_q <= SineRom[idx_i];
      entry_hi_q <= SineRom[idx_next];
    end
  end

  assign entry_lo_o = entry_lo_q;
  assign entry_hi_o = entry_hi_q;

endmodule

>>> hdl/phase_to_sine_interpolated.sv
// Phase-to-amplitude converter: quarter-wave sine table with linear interpolation.
// Top level; depends on phsin_pkg and phsin_rom.
//
// Usage:
// The slave channel takes one 32-bit phase word per transfer (full circle is
// 2^32). The master channel returns its sine as a signed value with FracBits
// fraction bits, zero-filled to whole bytes in m_axis_tdata.
// A transfer on the slave side passes through the table-read register stage
// and then the output register before its result is offered on the master side.
// The block takes one phase word in every cycle while the receiver is not
// stalling; the two-stage pipeline is table read, then interpolation multiply.
// When the receiver holds m_axis_tready low with a result waiting, the whole
// pipeline holds and s_axis_tready drops in the same cycle; no result is lost.
// Reset clears both pipeline valid flags, so no result is presented after it.
// The sine table is a constant and needs no loading after reset.
module phase_to_sine_interpolated #(
  parameter int unsigned TableSize = 256,
  parameter int unsigned FracBits  = 16
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    s_axis_tvalid,
  output logic                                    s_axis_tready,
  // Fields from bit 0: phase[31:0].
  input  logic [phsin_pkg::PhaseW-1:0]            s_axis_tdata,
  output logic                                    m_axis_tvalid,
  input  logic                                    m_axis_tready,
  // Fields from bit 0: sine_value[FracBits+1:0], then zero fill.
  output logic [((FracBits + 2 + 7) / 8) * 8-1:0] m_axis_tdata
);
  import phsin_pkg::*;

  localparam int unsigned IdxW  = $clog2(TableSize + 1);
  localparam int unsigned ScW   = QuarterW + IdxW;
  localparam int unsigned EntW  = FracBits + 1;
  localparam int unsigned ProdW = EntW + QuarterW;
  localparam int unsigned OutW  = FracBits + 2;
  localparam int unsigned TdW   = ((FracBits + 2 + 7) / 8) * 8;

  logic                advance;
  logic [QuarterW-1:0] offset;
  logic [ScW-1:0]      scaled;
  logic [IdxW-1:0]     idx_raw;
  logic [IdxW-1:0]     idx;
  logic                valid1_q;
  logic [QuarterW-1:0] frac_q;
  logic                sign_q;
  logic [EntW-1:0]     entry_lo;
  logic [EntW-1:0]     entry_hi;
  logic                rising;
  logic [EntW-1:0]     mag;
  logic [ProdW-1:0]    prod;
  logic [EntW-1:0]     delta;
  logic [EntW-1:0]     val;
  logic [OutW-1:0]     result;
  logic                out_valid_q;
  logic [TdW-1:0]      out_data_q;

  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = advance;

  assign offset  = s_axis_tdata[QuarterW-1:0] ^ {QuarterW{s_axis_tdata[QuarterW]}};
  assign scaled  = ScW'(offset) * ScW'(TableSize);
  assign idx_raw = scaled[ScW-1:QuarterW];
  assign idx     = (idx_raw > IdxW'(TableSize - 1)) ? IdxW'(TableSize - 1) : idx_raw;

  phsin_rom #(
    .TableSize (TableSize),
    .FracBits  (FracBits),
    .IdxW      (IdxW)
  ) u_rom (
    .clk_i      (clk_i),
    .en_i       (advance),
    .idx_i      (idx),
    .entry_lo_o (entry_lo),
    .entry_hi_o (entry_hi)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      valid1_q    <= s_axis_tvalid;
      out_valid_q <= valid1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      frac_q     <= scaled[QuarterW-1:0];
      sign_q     <= s_axis_tdata[PhaseW-1];
      out_data_q <= TdW'(result);
    end
  end

  always_comb begin
    rising = entry_hi >= entry_lo;
    mag    = rising ? (entry_hi - entry_lo) : (entry_lo - entry_hi);
    prod   = ProdW'(mag) * ProdW'(frac_q);
    delta  = prod[ProdW-1:QuarterW];
    val    = rising ? (entry_lo + delta) : (entry_lo - delta);
    result = sign_q ? (OutW'(0) - OutW'(val)) : OutW'(val);
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule
